/* design/idq_pkg.sv */
// ----------------------------------------------------------------------------
// idq_pkg: shared types and constants of the indexed double-ended queue
// Holds the sizes of the ring, the action codes, the payload structs and the
// request bundle that the sequencer hands to the ring memory.
// ----------------------------------------------------------------------------
`default_nettype none

package idq_pkg;

   // Ring size and word width.
   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);

   // Field widths of the transfer payloads.
   localparam int ACT_W = 3;
   localparam int POS_W = 5;
   localparam int CNT_W = 5;

   // Action codes carried by a request.
   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_GET        = 3'd4,
      ACT_SET        = 3'd5,
      ACT_CLEAR      = 3'd6
   } action_type;

   // Request payload.
   typedef struct packed {
      action_type              action;
      logic [POS_W-1:0]        position;
      logic [DATA_W-1:0]       write_data;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [DATA_W-1:0]       read_data;
      logic                    found;
      logic [CNT_W-1:0]        count;
      logic                    is_empty;
      logic                    overflow;
   } rsp_type;

   // One access of the ring memory per cycle.
   typedef struct packed {
      logic                    wr_en;
      logic                    rd_en;
      logic [PTR_W-1:0]        addr;
      logic [DATA_W-1:0]       wdata;
   } mem_req_type;

endpackage

`default_nettype wire

/* design/indexed_double_ended_queue.sv */
// A request passes through the execute and response states, and its response is then
// loaded into the output register once that is free. A get or set beyond the current
// length first passes through the pad state, which pushes zero words at the front
// and then makes the final access. No new request is taken until the sequencer is idle.
// Reset: synchronous; the queue comes out empty with the front pointer at zero.
// Ring contents are not cleared and read as whatever was last written.
// ----------------------------------------------------------------------------
// indexed_double_ended_queue: bounded deque with positional get and set
// A small sequencer drives one shared index adder and one memory port.
// The response sits in an output register, so a new request may be taken
// while the previous response still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_double_ended_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire idq_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output idq_pkg::rsp_type      rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PAD,
      ST_RESP
   } state_type;

   state_type                   state_ff,   state_in;
   idq_pkg::req_type            req_ff,     req_in;
   logic [idq_pkg::PTR_W-1:0]   front_ff,   front_in;
   logic [idq_pkg::CNT_W-1:0]   count_ff,   count_in;
   logic                        rd_sel_ff,  rd_sel_in;
   logic                        ovf_ff,     ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   idq_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [idq_pkg::PTR_W-1:0]   offset;
   logic [idq_pkg::PTR_W-1:0]   ring_index;
   logic [idq_pkg::DATA_W-1:0]  mem_rdata;
   idq_pkg::mem_req_type        mem_req;
   logic                        req_xfer;
   logic                        rsp_free;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Offset fed to the shared index adder for the current step.
   always_comb begin
      offset = '0;
      if (state_ff == ST_PAD) begin
         offset = idq_pkg::PTR_W'(idq_pkg::DEPTH - 1);
      end else if (state_ff == ST_EXEC) begin
         case (req_ff.action) inside
            idq_pkg::ACT_PUSH_FRONT: offset = idq_pkg::PTR_W'(idq_pkg::DEPTH - 1);
            idq_pkg::ACT_PUSH_BACK:  offset = count_ff[idq_pkg::PTR_W-1:0];
            idq_pkg::ACT_POP_FRONT:  offset = idq_pkg::PTR_W'(1);
            idq_pkg::ACT_POP_BACK:   offset = idq_pkg::PTR_W'(count_ff - idq_pkg::CNT_W'(1));
            idq_pkg::ACT_GET, idq_pkg::ACT_SET: begin
               offset = idq_pkg::PTR_W'(count_ff - req_ff.position);
            end
            default: offset = '0;
         endcase
      end
   end

   idq_index_unit u_index (
      .base   (front_ff),
      .offset (offset),
      .index  (ring_index)
   );

   idq_ring_mem u_ring (
      .clock    (clock),
      .mem_req  (mem_req),
      .rdata_ff (mem_rdata)
   );

   // Sequencer: next state, pointer updates and the memory access.
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      rd_sel_in      = rd_sel_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_req        = '0;
      mem_req.wdata  = req_ff.write_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in    = req_payload;
               rd_sel_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            case (req_ff.action) inside
               idq_pkg::ACT_PUSH_FRONT: begin
                  if (count_ff == idq_pkg::CNT_W'(idq_pkg::DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     mem_req.addr  = ring_index;
                     front_in      = ring_index;
                     count_in      = count_ff + idq_pkg::CNT_W'(1);
                  end
               end
               idq_pkg::ACT_PUSH_BACK: begin
                  if (count_ff == idq_pkg::CNT_W'(idq_pkg::DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     mem_req.addr  = ring_index;
                     count_in      = count_ff + idq_pkg::CNT_W'(1);
                  end
               end
               idq_pkg::ACT_POP_FRONT: begin
                  if (count_ff != '0) begin
                     mem_req.rd_en = 1'b1;
                     mem_req.addr  = front_ff;
                     rd_sel_in     = 1'b1;
                     front_in      = ring_index;
                     count_in      = count_ff - idq_pkg::CNT_W'(1);
                  end
               end
               idq_pkg::ACT_POP_BACK: begin
                  if (count_ff != '0) begin
                     mem_req.rd_en = 1'b1;
                     mem_req.addr  = ring_index;
                     rd_sel_in     = 1'b1;
                     count_in      = count_ff - idq_pkg::CNT_W'(1);
                  end
               end
               idq_pkg::ACT_GET, idq_pkg::ACT_SET: begin
                  if (req_ff.position > idq_pkg::POS_W'(idq_pkg::DEPTH)) begin
                     ovf_in = 1'b1;
                  end else if (req_ff.position == '0) begin
                     // Front element, when there is one.
                     if (count_ff != '0) begin
                        mem_req.addr = front_ff;
                        if (req_ff.action == idq_pkg::ACT_GET) begin
                           mem_req.rd_en = 1'b1;
                           rd_sel_in     = 1'b1;
                        end else begin
                           mem_req.wr_en = 1'b1;
                        end
                     end
                  end else if (req_ff.position <= count_ff) begin
                     mem_req.addr = ring_index;
                     if (req_ff.action == idq_pkg::ACT_GET) begin
                        mem_req.rd_en = 1'b1;
                        rd_sel_in     = 1'b1;
                     end else begin
                        mem_req.wr_en = 1'b1;
                     end
                  end else begin
                     state_in = ST_PAD;
                  end
               end
               idq_pkg::ACT_CLEAR: begin
                  count_in = '0;
                  front_in = '0;
               end
               default: begin
               end
            endcase
         end

         // Push zero words at the front until the length reaches the position,
         // then access the new front element.
         ST_PAD: begin
            if (count_ff < req_ff.position) begin
               mem_req.wr_en = 1'b1;
               mem_req.addr  = ring_index;
               mem_req.wdata = '0;
               front_in      = ring_index;
               count_in      = count_ff + idq_pkg::CNT_W'(1);
            end else begin
               mem_req.addr = front_ff;
               if (req_ff.action == idq_pkg::ACT_GET) begin
                  mem_req.rd_en = 1'b1;
                  rd_sel_in     = 1'b1;
               end else begin
                  mem_req.wr_en = 1'b1;
               end
               state_in = ST_RESP;
            end
         end

         // Load the output register once it is free.
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.read_data = rd_sel_ff ? mem_rdata : '0;
               rsp_payload_in.found     = rd_sel_ff;
               rsp_payload_in.count     = count_ff;
               rsp_payload_in.is_empty  = (count_ff == '0);
               rsp_payload_in.overflow  = ovf_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff         <= req_in;
      rd_sel_ff      <= rd_sel_in;
      ovf_ff         <= ovf_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // The element count never passes the ring size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= idq_pkg::CNT_W'(idq_pkg::DEPTH))
      else $error("element count exceeds ring size");

   // The memory port is used for one access per cycle.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("read and write in the same cycle");

   // A response never reports both a found element and an overflow.
   a_found_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_ff.found && rsp_payload_ff.overflow))
      else $error("found and overflow both set");

   // Each padding step adds exactly one element.
   a_pad_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && count_ff < req_ff.position)
         |=> count_ff == $past(count_ff) + idq_pkg::CNT_W'(1))
      else $error("padding step did not grow the queue by one");

   // A request transfer starts execution in the next cycle.
   a_xfer_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_EXEC)
      else $error("accepted request did not start execution");

endmodule

`default_nettype wire

/* design/idq_index_unit.sv */
// ----------------------------------------------------------------------------
// idq_index_unit: shared ring index adder
// Adds an offset to the front pointer and wraps the sum into the ring.
// Both operands are below DEPTH, so one compare and subtract is enough.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_index_unit (
   input  wire logic [idq_pkg::PTR_W-1:0] base,
   input  wire logic [idq_pkg::PTR_W-1:0] offset,
   output logic      [idq_pkg::PTR_W-1:0] index
);

   logic [idq_pkg::PTR_W:0] sum;
   logic [idq_pkg::PTR_W:0] wrapped;

   // Add, then fold back once when the sum passes the end of the ring.
   always_comb begin
      sum     = {1'b0, base} + {1'b0, offset};
      wrapped = sum - (idq_pkg::PTR_W + 1)'(idq_pkg::DEPTH);
      if (sum >= (idq_pkg::PTR_W + 1)'(idq_pkg::DEPTH)) begin
         index = wrapped[idq_pkg::PTR_W-1:0];
      end else begin
         index = sum[idq_pkg::PTR_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* design/idq_ring_mem.sv */
// ----------------------------------------------------------------------------
// idq_ring_mem: ring storage of the queue
// Single-port memory of DEPTH words, one write or one read per cycle.
// Read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module idq_ring_mem (
   input  wire logic                       clock,
   input  wire idq_pkg::mem_req_type       mem_req,
   output logic      [idq_pkg::DATA_W-1:0] rdata_ff
);

   logic [idq_pkg::DATA_W-1:0] store_ff [idq_pkg::DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.addr] <= mem_req.wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rdata_ff <= store_ff[mem_req.addr];
      end
   end

endmodule

`default_nettype wire
